// ===== rtl/core/odp_pkg.sv =====
// shared types, constants and lookup functions for the ordered dither palette blend core
`default_nettype none
package odp_pkg;

  // channel order inside packed channel arrays: 0 red, 1 green, 2 blue
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned NUM_PAL = 16;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned WGT_W   = 9;
  localparam int unsigned MIX_W   = 20;

  // unity weight for bias and fade
  localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

  // register indexes on the config port
  localparam logic REG_PALETTE_BIAS = 1'b0;
  localparam logic REG_FADE_LEVEL   = 1'b1;

  // palette channel level codes
  localparam logic [1:0] LVL_ZERO = 2'd0;
  localparam logic [1:0] LVL_HALF = 2'd1;
  localparam logic [1:0] LVL_FULL = 2'd2;

  typedef struct packed {
    logic [RAW_W-1:0] red_raw;
    logic [RAW_W-1:0] green_raw;
    logic [RAW_W-1:0] blue_raw;
    logic [1:0]       x_phase;
    logic [1:0]       y_phase;
  } pix_in_t;

  typedef struct packed {
    logic [15:0]      pixel_rgb565;
    logic [IDX_W-1:0] palette_index;
  } pix_out_t;

  // dither stage payload
  typedef struct packed {
    logic [NUM_CH-1:0][RAW_W-1:0] raw;
    logic [NUM_CH-1:0][PIX_W-1:0] dith;
  } dith_t;

  // match stage payload
  typedef struct packed {
    logic [NUM_CH-1:0][RAW_W-1:0] raw;
    logic [IDX_W-1:0]             idx;
  } match_t;

  // 4x4 bayer matrix, row y, column x
  function automatic logic [3:0] bayer_entry(logic [1:0] y, logic [1:0] x);
    logic [3:0] m;
    case ({y, x})
      4'd0:    m = 4'd0;
      4'd1:    m = 4'd8;
      4'd2:    m = 4'd2;
      4'd3:    m = 4'd10;
      4'd4:    m = 4'd12;
      4'd5:    m = 4'd4;
      4'd6:    m = 4'd14;
      4'd7:    m = 4'd6;
      4'd8:    m = 4'd3;
      4'd9:    m = 4'd11;
      4'd10:   m = 4'd1;
      4'd11:   m = 4'd9;
      4'd12:   m = 4'd15;
      4'd13:   m = 4'd7;
      4'd14:   m = 4'd13;
      default: m = 4'd5;
    endcase
    return m;
  endfunction

  // dither offset in Q.4 for each bayer entry
  function automatic logic signed [9:0] dither_offset(logic [3:0] m);
    logic signed [9:0] o;
    case (m)
      4'd0:    o = -10'sd256;
      4'd1:    o = -10'sd222;
      4'd2:    o = -10'sd188;
      4'd3:    o = -10'sd154;
      4'd4:    o = -10'sd119;
      4'd5:    o = -10'sd85;
      4'd6:    o = -10'sd51;
      4'd7:    o = -10'sd17;
      4'd8:    o = 10'sd17;
      4'd9:    o = 10'sd51;
      4'd10:   o = 10'sd85;
      4'd11:   o = 10'sd119;
      4'd12:   o = 10'sd154;
      4'd13:   o = 10'sd188;
      4'd14:   o = 10'sd222;
      default: o = 10'sd256;
    endcase
    return o;
  endfunction

  // palette entry as level codes {red, green, blue}
  function automatic logic [5:0] pal_levels(logic [3:0] idx);
    logic [5:0] l;
    case (idx)
      4'd0:    l = {LVL_ZERO, LVL_ZERO, LVL_ZERO};
      4'd1:    l = {LVL_ZERO, LVL_ZERO, LVL_HALF};
      4'd2:    l = {LVL_ZERO, LVL_ZERO, LVL_FULL};
      4'd3:    l = {LVL_HALF, LVL_ZERO, LVL_ZERO};
      4'd4:    l = {LVL_HALF, LVL_ZERO, LVL_HALF};
      4'd5:    l = {LVL_ZERO, LVL_HALF, LVL_HALF};
      4'd6:    l = {LVL_ZERO, LVL_HALF, LVL_FULL};
      4'd7:    l = {LVL_FULL, LVL_ZERO, LVL_HALF};
      4'd8:    l = {LVL_FULL, LVL_ZERO, LVL_FULL};
      4'd9:    l = {LVL_ZERO, LVL_HALF, LVL_ZERO};
      4'd10:   l = {LVL_ZERO, LVL_FULL, LVL_FULL};
      4'd11:   l = {LVL_HALF, LVL_FULL, LVL_ZERO};
      4'd12:   l = {LVL_FULL, LVL_FULL, LVL_ZERO};
      4'd13:   l = {LVL_FULL, LVL_FULL, LVL_FULL};
      4'd14:   l = {LVL_ZERO, LVL_FULL, LVL_ZERO};
      default: l = {LVL_FULL, LVL_HALF, LVL_ZERO};
    endcase
    return l;
  endfunction

  // 8-bit channel value of a level code
  function automatic logic [PIX_W-1:0] level_value(logic [1:0] l);
    logic [PIX_W-1:0] v;
    case (l)
      LVL_ZERO: v = 8'd0;
      LVL_HALF: v = 8'd128;
      default:  v = 8'd255;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ordered_dither_palette_blend_core.sv =====
// top level of the ordered dither palette blend core with its config registers
//
// Pixels enter on the in channel (in_valid_i / in_ready_o / in_data_i), one
// transaction per pixel with its x and y phase; results leave on the out
// channel (out_valid_o / out_ready_i / out_data_o) in the same order.
// The datapath is a seven-stage pipeline: dither, channel squares, distance
// sums, two min-tree stages, blend mix and fade/pack. A pixel passes the
// stage registers in that order and its result waits in the fade/pack output
// register until taken; one pixel per cycle is sustained while the receiver
// takes results, as all stages share a single global stage enable.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready_o drops in the same cycle; nothing is lost or duplicated.
// The APB port holds palette_bias at 0x0 and fade_level at 0x4, both 9 bits
// and reset to 256; values above 256 act as 256. Writes belong only to idle
// periods. Reset clears all pipeline valid bits and restores both registers.
`default_nettype none
module ordered_dither_palette_blend_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire odp_pkg::pix_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output odp_pkg::pix_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import odp_pkg::*;

  logic [WGT_W-1:0] bias_q, fade_q;
  logic [WGT_W-1:0] bias_sat, fade_sat;
  logic [WGT_W-1:0] rd_val;
  logic             advance;
  logic             dith_valid, match_valid;
  dith_t            dith_data;
  match_t           match_data;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= WGT_ONE;
      fade_q <= WGT_ONE;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PALETTE_BIAS: bias_q <= pwdata[WGT_W-1:0];
        REG_FADE_LEVEL:   fade_q <= pwdata[WGT_W-1:0];
        default:          ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[2])
      REG_PALETTE_BIAS: rd_val = bias_q;
      REG_FADE_LEVEL:   rd_val = fade_q;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(32-WGT_W){1'b0}}, rd_val};
  assign pready = 1'b1;

  // weights above unity act as unity
  assign bias_sat = (bias_q > WGT_ONE) ? WGT_ONE : bias_q;
  assign fade_sat = (fade_q > WGT_ONE) ? WGT_ONE : fade_q;

  // whole pipeline moves unless the output holds an untaken result
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  odp_dither u_dither (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (in_valid_i),
    .data_i    (in_data_i),
    .valid_o   (dith_valid),
    .data_o    (dith_data)
  );

  odp_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (dith_valid),
    .data_i    (dith_data),
    .valid_o   (match_valid),
    .data_o    (match_data)
  );

  odp_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .bias_i    (bias_sat),
    .fade_i    (fade_sat),
    .valid_i   (match_valid),
    .data_i    (match_data),
    .valid_o   (out_valid_o),
    .data_o    (out_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/odp_dither.sv =====
// dither stage: bayer offset, truncate and clamp of each channel
`default_nettype none
module odp_dither (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire logic            valid_i,
  input  wire odp_pkg::pix_in_t data_i,
  output logic                 valid_o,
  output odp_pkg::dith_t       data_o
);
  import odp_pkg::*;

  logic signed [9:0]              off;
  logic [NUM_CH-1:0][RAW_W-1:0]   raw_in;
  logic signed [13:0]             sum [NUM_CH];
  dith_t                          data_d, data_q;
  logic                           valid_q;

  assign raw_in[0] = data_i.red_raw;
  assign raw_in[1] = data_i.green_raw;
  assign raw_in[2] = data_i.blue_raw;
  assign off = dither_offset(bayer_entry(data_i.y_phase, data_i.x_phase));

  // add offset, floor at zero, shift out the fraction, saturate at 255
  always_comb begin
    data_d.raw = raw_in;
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = $signed({2'b00, raw_in[c]}) + $signed({{4{off[9]}}, off});
      if (sum[c][13]) begin
        data_d.dith[c] = '0;
      end else if (sum[c][12]) begin
        data_d.dith[c] = '1;
      end else begin
        data_d.dith[c] = sum[c][11:4];
      end
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/odp_match.sv =====
// nearest palette search: squares, distance sums and a two-stage min tree
`default_nettype none
module odp_match (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           advance_i,
  input  wire logic           valid_i,
  input  wire odp_pkg::dith_t data_i,
  output logic                valid_o,
  output odp_pkg::match_t     data_o
);
  import odp_pkg::*;

  typedef logic [NUM_CH-1:0][RAW_W-1:0] raw3_t;

  // squared channel distances to the three levels
  logic signed [8:0]  diff [NUM_CH][3];
  logic signed [17:0] prod [NUM_CH][3];
  logic [SQ_W-1:0]    sq_q [NUM_CH][3];
  raw3_t              raw_b_q;
  logic               valid_b_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int l = 0; l < 3; l++) begin
        diff[c][l] = $signed({1'b0, data_i.dith[c]}) - $signed({1'b0, level_value(2'(l))});
        prod[c][l] = diff[c][l] * diff[c][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int l = 0; l < 3; l++) begin
          sq_q[c][l] <= prod[c][l][SQ_W-1:0];
        end
      end
      raw_b_q <= data_i.raw;
    end
  end

  // distance sum for each palette entry
  logic [DIST_W-1:0] dist_d [NUM_PAL];
  logic [DIST_W-1:0] dist_q [NUM_PAL];
  raw3_t             raw_c_q;
  logic              valid_c_q;

  for (genvar i = 0; i < NUM_PAL; i++) begin : g_dist
    localparam logic [5:0] Lvl = pal_levels(4'(i));
    assign dist_d[i] = DIST_W'(sq_q[0][Lvl[5:4]]) + DIST_W'(sq_q[1][Lvl[3:2]])
                     + DIST_W'(sq_q[2][Lvl[1:0]]);
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      dist_q  <= dist_d;
      raw_c_q <= raw_b_q;
    end
  end

  // first min tree stage: 16 to 4, lower index kept on ties
  logic [DIST_W-1:0] l1_dist [8];
  logic [IDX_W-1:0]  l1_idx  [8];
  logic [DIST_W-1:0] l2_dist [4];
  logic [IDX_W-1:0]  l2_idx  [4];
  logic [DIST_W-1:0] grp_dist_q [4];
  logic [IDX_W-1:0]  grp_idx_q  [4];
  raw3_t             raw_d_q;
  logic              valid_d_q;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      if (dist_q[2*p+1] < dist_q[2*p]) begin
        l1_dist[p] = dist_q[2*p+1];
        l1_idx[p]  = IDX_W'(2*p+1);
      end else begin
        l1_dist[p] = dist_q[2*p];
        l1_idx[p]  = IDX_W'(2*p);
      end
    end
    for (int p = 0; p < 4; p++) begin
      if (l1_dist[2*p+1] < l1_dist[2*p]) begin
        l2_dist[p] = l1_dist[2*p+1];
        l2_idx[p]  = l1_idx[2*p+1];
      end else begin
        l2_dist[p] = l1_dist[2*p];
        l2_idx[p]  = l1_idx[2*p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      grp_dist_q <= l2_dist;
      grp_idx_q  <= l2_idx;
      raw_d_q    <= raw_c_q;
    end
  end

  // second min tree stage: 4 to 1
  logic [DIST_W-1:0] l3_dist [2];
  logic [IDX_W-1:0]  l3_idx  [2];
  match_t            data_d, data_q;
  logic              valid_e_q;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (grp_dist_q[2*p+1] < grp_dist_q[2*p]) begin
        l3_dist[p] = grp_dist_q[2*p+1];
        l3_idx[p]  = grp_idx_q[2*p+1];
      end else begin
        l3_dist[p] = grp_dist_q[2*p];
        l3_idx[p]  = grp_idx_q[2*p];
      end
    end
    data_d.raw = raw_d_q;
    data_d.idx = (l3_dist[1] < l3_dist[0]) ? l3_idx[1] : l3_idx[0];
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= data_d;
    end
  end

  // valid bits of the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else if (advance_i) begin
      valid_b_q <= valid_i;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
      valid_e_q <= valid_d_q;
    end
  end

  assign valid_o = valid_e_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/odp_blend.sv =====
// blend of palette and raw color, fade scaling and rgb565 packing
`default_nettype none
module odp_blend (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic [odp_pkg::WGT_W-1:0]    bias_i,
  input  wire logic [odp_pkg::WGT_W-1:0]    fade_i,
  input  wire logic                         valid_i,
  input  wire odp_pkg::match_t              data_i,
  output logic                              valid_o,
  output odp_pkg::pix_out_t                 data_o
);
  import odp_pkg::*;

  logic [5:0]        lvl;
  logic [WGT_W-1:0]  inv_bias;
  logic [PIX_W-1:0]  pal [NUM_CH];
  logic [20:0]       mix_d [NUM_CH];
  logic [MIX_W-1:0]  mix_q [NUM_CH];
  logic [IDX_W-1:0]  idx_q;
  logic              valid_f_q;

  assign lvl      = pal_levels(data_i.idx);
  assign inv_bias = WGT_ONE - bias_i;
  assign pal[0]   = level_value(lvl[5:4]);
  assign pal[1]   = level_value(lvl[3:2]);
  assign pal[2]   = level_value(lvl[1:0]);

  // weighted mix in units of 2^-12, fits 20 bits
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      mix_d[c] = 21'({pal[c], 4'b0000} * bias_i) + 21'(data_i.raw[c] * inv_bias);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        mix_q[c] <= mix_d[c][MIX_W-1:0];
      end
      idx_q <= data_i.idx;
    end
  end

  // fade and pack into the output register
  logic [28:0]      faded [NUM_CH];
  logic [PIX_W-1:0] ch [NUM_CH];
  pix_out_t         out_d, out_q;
  logic             valid_g_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      faded[c] = 29'(mix_q[c] * fade_i);
      ch[c]    = faded[c][27:20];
    end
    out_d.pixel_rgb565  = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
    out_d.palette_index = idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_f_q <= 1'b0;
      valid_g_q <= 1'b0;
    end else if (advance_i) begin
      valid_f_q <= valid_i;
      valid_g_q <= valid_f_q;
    end
  end

  assign valid_o = valid_g_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/odp_checker.sv =====
// port-level checker for the ordered dither palette blend core and its bind
`default_nettype none
module odp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire odp_pkg::pix_out_t out_data_o,
  input wire logic              psel,
  input wire logic              pwrite,
  input wire logic [31:0]       prdata
);
  import odp_pkg::*;

  // no result is shown while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // input is taken exactly when the output register is free or being drained
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not track output register state");

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  // register readback never shows bits above the 9-bit weights
  a_readback_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !pwrite) |-> (prdata[31:WGT_W] == '0))
    else $error("readback carries bits above the register width");

endmodule

bind ordered_dither_palette_blend_core odp_checker u_odp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .pwrite      (pwrite),
  .prdata      (prdata)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the ordered dither palette blend core
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import odp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_PRINTED  = 40;

  // register byte addresses on the config port
  localparam logic [2:0] BIAS_ADDR = {REG_PALETTE_BIAS, 2'b00};
  localparam logic [2:0] FADE_ADDR = {REG_FADE_LEVEL, 2'b00};

  // palette colors as {red, green, blue}, entry 15 first
  localparam logic [15:0][23:0] PAL_RGB = {
    24'hFF8000, 24'h00FF00, 24'hFFFFFF, 24'hFFFF00,
    24'h80FF00, 24'h00FFFF, 24'h008000, 24'hFF00FF,
    24'hFF0080, 24'h0080FF, 24'h008080, 24'h800080,
    24'h800000, 24'h0000FF, 24'h000080, 24'h000000
  };

  // bayer threshold indexed by {y, x}, entry 15 first
  localparam logic [15:0][3:0] BAYER = {
    4'd5, 4'd13, 4'd7, 4'd15, 4'd9, 4'd1, 4'd11, 4'd3,
    4'd6, 4'd14, 4'd4, 4'd12, 4'd10, 4'd2, 4'd8, 4'd0
  };

  // dither offset in sixteenths per bayer threshold, entry 15 first
  localparam logic [15:0][9:0] DITHER_Q4 = {
    10'sd256, 10'sd222, 10'sd188, 10'sd154, 10'sd119, 10'sd85, 10'sd51, 10'sd17,
    -10'sd17, -10'sd51, -10'sd85, -10'sd119, -10'sd154, -10'sd188, -10'sd222,
    -10'sd256
  };

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

  // expected pixel store and predictor
  class pixel_scoreboard;
    pix_out_t         expected_pixels[$];
    logic [WGT_W-1:0] bias_reg;
    logic [WGT_W-1:0] fade_reg;
    int unsigned      errors;
    int unsigned      accepted;
    int unsigned      checked;
    logic [NUM_PAL-1:0] index_seen;

    function new();
      bias_reg   = WGT_ONE;
      fade_reg   = WGT_ONE;
      errors     = 0;
      accepted   = 0;
      checked    = 0;
      index_seen = '0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == BIAS_ADDR) begin
        bias_reg = data[WGT_W-1:0];
      end else if (addr == FADE_ADDR) begin
        fade_reg = data[WGT_W-1:0];
      end
    endfunction

    function pix_out_t predict_pixel(pix_in_t p);
      int raw [NUM_CH];
      int dith [NUM_CH];
      int ofs, s, dr, dg, db, d, best_d, bias, fade;
      logic [3:0] best;
      longint unsigned pc, mix, v;
      logic [7:0] ch [NUM_CH];
      pix_out_t r;
      raw[0] = p.red_raw;
      raw[1] = p.green_raw;
      raw[2] = p.blue_raw;
      ofs = int'($signed(DITHER_Q4[BAYER[{p.y_phase, p.x_phase}]]));
      // dither, truncate and clamp each channel
      for (int c = 0; c < NUM_CH; c++) begin
        s = raw[c] + ofs;
        if (s < 0) begin
          dith[c] = 0;
        end else begin
          dith[c] = s >>> 4;
          if (dith[c] > 255) dith[c] = 255;
        end
      end
      // nearest palette entry, lowest index on ties
      best_d = 32'h7FFFFFFF;
      best   = '0;
      for (int i = 0; i < NUM_PAL; i++) begin
        dr = dith[0] - int'(PAL_RGB[i][23:16]);
        dg = dith[1] - int'(PAL_RGB[i][15:8]);
        db = dith[2] - int'(PAL_RGB[i][7:0]);
        d  = dr * dr + dg * dg + db * db;
        if (d < best_d) begin
          best_d = d;
          best   = 4'(i);
        end
      end
      // blend with raw, then fade
      bias = (bias_reg > WGT_ONE) ? int'(WGT_ONE) : int'(bias_reg);
      fade = (fade_reg > WGT_ONE) ? int'(WGT_ONE) : int'(fade_reg);
      for (int c = 0; c < NUM_CH; c++) begin
        pc  = PAL_RGB[best][23-8*c -: 8];
        mix = (pc << 4) * longint'(bias) + longint'(raw[c]) * longint'(int'(WGT_ONE) - bias);
        v   = (mix * longint'(fade)) >> 20;
        if (v > 255) v = 255;
        ch[c] = v[7:0];
      end
      r.pixel_rgb565  = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
      r.palette_index = best;
      return r;
    endfunction

    function void note_pixel(pix_in_t p);
      pix_out_t e;
      e = predict_pixel(p);
      expected_pixels.push_back(e);
      index_seen[e.palette_index] = 1'b1;
      accepted++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(pix_out_t got);
      pix_out_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h with no pixel pending", got));
      end else begin
        e = expected_pixels.pop_front();
        checked++;
        if (got.pixel_rgb565 !== e.pixel_rgb565)
          report($sformatf("pixel_rgb565 got %h want %h (result %0d)",
                           got.pixel_rgb565, e.pixel_rgb565, checked));
        if (got.palette_index !== e.palette_index)
          report($sformatf("palette_index got %0d want %0d (result %0d)",
                           got.palette_index, e.palette_index, checked));
      end
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pix_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit          hold_request = 1'b0;
  int          cycle_count  = 0;
  int          settings_used = 1;
  pixel_scoreboard sb = new();

  ordered_dither_palette_blend_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: changing stall patterns plus one long hold on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    out_ready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_HALF:    out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // offer one pixel and hold it until accepted; call at a falling edge
  task automatic send_pixel(input pix_in_t p);
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // stop offering until every expected result is back, then let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // write both registers, sometimes with junk above the 9 valid bits
  task automatic set_weights(input int bias, input int fade);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? ($urandom() & ~32'h1FF) : 32'h0;
    apb_write(BIAS_ADDR, junk | 32'(bias));
    junk = $urandom_range(0, 1) ? ($urandom() & ~32'h1FF) : 32'h0;
    apb_write(FADE_ADDR, junk | 32'(fade));
    settings_used++;
  endtask

  function automatic pix_in_t make_pixel(int r, int g, int b, int x, int y);
    pix_in_t p;
    p.red_raw   = 12'(r);
    p.green_raw = 12'(g);
    p.blue_raw  = 12'(b);
    p.x_phase   = 2'(x);
    p.y_phase   = 2'(y);
    return p;
  endfunction

  // random pixel: mostly uniform, some near palette colors, extremes and midpoints
  function automatic pix_in_t rand_pixel();
    int v [NUM_CH];
    int kind, pi;
    kind = $urandom_range(0, 9);
    pi   = $urandom_range(0, NUM_PAL - 1);
    for (int c = 0; c < NUM_CH; c++) begin
      if (kind <= 5) begin
        v[c] = $urandom_range(0, 4095);
      end else if (kind <= 7) begin
        v[c] = int'(PAL_RGB[pi][23-8*c -: 8]) * 16 + $urandom_range(0, 600) - 300;
      end else if (kind == 8) begin
        case ($urandom_range(0, 3))
          0:       v[c] = 0;
          1:       v[c] = 4095;
          2:       v[c] = $urandom_range(0, 63);
          default: v[c] = 4095 - $urandom_range(0, 63);
        endcase
      end else begin
        v[c] = ($urandom_range(0, 1) ? 1024 : 3072) + $urandom_range(0, 511) - 256;
      end
      if (v[c] < 0) v[c] = 0;
      if (v[c] > 4095) v[c] = 4095;
    end
    return make_pixel(v[0], v[1], v[2], $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  // edge cases: exact palette colors over every phase, clamps and ties
  task automatic run_directed();
    for (int i = 0; i < NUM_PAL; i++)
      send_pixel(make_pixel(int'(PAL_RGB[i][23:16]) * 16, int'(PAL_RGB[i][15:8]) * 16,
                            int'(PAL_RGB[i][7:0]) * 16, i % 4, i / 4));
    // negative sums clamp to zero
    send_pixel(make_pixel(0, 0, 0, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 3, 3));
    // positive offsets on full-scale channels saturate at 255
    send_pixel(make_pixel(4095, 4095, 4095, 0, 3));
    send_pixel(make_pixel(4095, 0, 4095, 2, 1));
    send_pixel(make_pixel(0, 4095, 0, 1, 2));
    // exact midpoints between two palette entries, lower index wins
    send_pixel(make_pixel(1280, 256, 256, 0, 0));
    send_pixel(make_pixel(256, 256, 1280, 0, 0));
  endtask

  // random bursts with gaps; optional long receiver hold and mid-run drain
  task automatic run_random(input int count, input bit long_hold, input bit mid_drain);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < count; j++) begin
        if (long_hold && sent == count / 3) hold_request = 1'b1;
        if (mid_drain && sent == count / 2) wait_idle();
        send_pixel(rand_pixel());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_input(gap);
    end
  endtask

  // main sequence
  initial begin
    int bias_plan [8];
    int fade_plan [8];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    bias_plan = '{0, 256, 128, 511, 257, 64, 0, 200};
    fade_plan = '{256, 0, 200, 511, 128, 300, 0, 257};
    bias_plan[6] = $urandom_range(0, 511);
    fade_plan[6] = $urandom_range(0, 511);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset weights first
    run_directed();
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      set_weights(bias_plan[k], fade_plan[k]);
      run_random(PHASE_ITEMS, k == 1, k == 3);
      wait_idle();
    end

    $display("covered %0d pixels under %0d weight settings, %0d results compared",
             sb.accepted, settings_used, sb.checked);
    $display("palette entries reached: %0d of %0d, mismatches: %0d",
             $countones(sb.index_seen), NUM_PAL, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/odp_pkg.sv
rtl/core/odp_dither.sv
rtl/core/odp_match.sv
rtl/core/odp_blend.sv
rtl/core/ordered_dither_palette_blend_core.sv
rtl/core/odp_checker.sv
tb/tb_top.sv
